// ===== rtl/fct_pkg.sv =====
// shared types, constants and helpers for the fat12 cluster table
package fct_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int CMD_W         = 2;
  localparam int CL_W          = 12;
  localparam int ENTRY_W       = 12;

  localparam logic [ADDR_W-1:0]  FIRST_DATA_CLUSTER = ADDR_W'(2);
  localparam logic [ADDR_W-1:0]  LAST_ADDR          = ADDR_W'(TABLE_ENTRIES - 1);
  localparam logic [ENTRY_W-1:0] RESET_ENTRY0       = 12'hFF0;
  localparam logic [ENTRY_W-1:0] RESET_ENTRY1       = 12'hFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2
  } fct_cmd_e_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_DONE
  } fct_state_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CL_W-1:0]  cluster;
    logic [CL_W-1:0]  write_value;
  } fct_in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry_value;
    logic               found;
    logic [CL_W-1:0]    first_free;
  } fct_out_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic scan_step;
    logic ld_read;
    logic ld_found;
    logic ld_zero;
    logic out_load;
  } fct_dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic scan_zero;
    logic scan_last;
  } fct_dp_sts_t;

  function automatic logic [ENTRY_W-1:0] reset_entry(input logic [ADDR_W-1:0] addr);
    logic [ENTRY_W-1:0] val;
    val = '0;
    if (addr == ADDR_W'(0)) begin
      val = RESET_ENTRY0;
    end else if (addr == ADDR_W'(1)) begin
      val = RESET_ENTRY1;
    end
    return val;
  endfunction

endpackage

// ===== rtl/fct_ram.sv =====
// generic single-write, single-read ram with registered read data
module fct_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fct_datapath.sv =====
// datapath: table ram, clear and scan address counters, result and output registers
module fct_datapath import fct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  fct_in_t     in_data,
  input  fct_dp_cmd_t dp_cmd,
  output fct_dp_sts_t dp_sts,
  output fct_out_t    out_data
);

  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic               in_tbl_r, in_tbl_nxt;
  fct_out_t           res_r, res_nxt;
  fct_out_t           out_r, out_nxt;
  logic               in_tbl;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  assign in_tbl = ({1'b0, in_data.cluster} < (CL_W + 1)'(TABLE_ENTRIES));

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    if (dp_cmd.clear_wr) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
    end

    // the read address always follows the next scan address
    scan_addr_nxt = scan_addr_r;
    in_tbl_nxt    = in_tbl_r;
    if (dp_cmd.accept) begin
      in_tbl_nxt = in_tbl;
      if (in_data.cmd == CMD_FIND) begin
        scan_addr_nxt = FIRST_DATA_CLUSTER;
      end else begin
        scan_addr_nxt = in_data.cluster[ADDR_W-1:0];
      end
    end else if (dp_cmd.scan_step) begin
      scan_addr_nxt = scan_addr_r + ADDR_W'(1);
    end

    ram_we    = 1'b0;
    ram_waddr = in_data.cluster[ADDR_W-1:0];
    ram_wdata = in_data.write_value;
    if (dp_cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = reset_entry(clr_addr_r);
    end else if (dp_cmd.accept && in_data.cmd == CMD_WRITE && in_tbl) begin
      ram_we = 1'b1;
    end

    res_nxt = res_r;
    if (dp_cmd.ld_zero) begin
      res_nxt = '0;
    end else if (dp_cmd.ld_read) begin
      res_nxt             = '0;
      res_nxt.entry_value = in_tbl_r ? ram_rdata : '0;
    end else if (dp_cmd.ld_found) begin
      res_nxt            = '0;
      res_nxt.found      = 1'b1;
      res_nxt.first_free = CL_W'(scan_addr_r);
    end

    out_nxt = dp_cmd.out_load ? res_r : out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    in_tbl_r    <= in_tbl_nxt;
    res_r       <= res_nxt;
    out_r       <= out_nxt;
  end

  fct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr_nxt),
    .rdata (ram_rdata)
  );

  assign dp_sts.clr_last  = (clr_addr_r == LAST_ADDR);
  assign dp_sts.scan_zero = (ram_rdata == '0);
  assign dp_sts.scan_last = (scan_addr_r == LAST_ADDR);
  assign out_data         = out_r;

endmodule

// ===== rtl/fct_ctrl.sv =====
// controller: clearing pass, command sequencing and output valid
module fct_ctrl import fct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fct_dp_cmd_t      dp_cmd,
  input  fct_dp_sts_t      dp_sts
);

  fct_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    in_ready  = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        dp_cmd.clear_wr = 1'b1;
        if (dp_sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.accept = 1'b1;
          if (in_cmd == CMD_READ) begin
            state_nxt = ST_RD;
          end else if (in_cmd == CMD_FIND) begin
            state_nxt = ST_SCAN;
          end else begin
            // write and the unused code both answer all zero
            dp_cmd.ld_zero = 1'b1;
            state_nxt      = ST_DONE;
          end
        end
      end
      ST_RD: begin
        dp_cmd.ld_read = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_SCAN: begin
        priority if (dp_sts.scan_zero) begin
          dp_cmd.ld_found = 1'b1;
          state_nxt       = ST_DONE;
        end else if (dp_sts.scan_last) begin
          dp_cmd.ld_zero = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          dp_cmd.scan_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.out_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (dp_cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/fat12_cluster_table_unit.sv =====
// fat12 cluster table: 4096 x 12-bit entries with read, write and find-free commands
// after reset a clearing pass writes the reset entry of every address; no
// transaction is accepted until it ends. one command at a time: write and the unused
// code go from acceptance to ST_DONE, read through ST_RD (registered ram read),
// find-free scans from cluster 2 to the first zero entry, or answers zero when full;
// the next command is accepted in the cycle its result turns valid
module fat12_cluster_table_unit import fct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fct_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output fct_out_t out_data
);

  fct_dp_cmd_t dp_cmd;
  fct_dp_sts_t dp_sts;

  fct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  fct_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .dp_cmd   (dp_cmd),
    .dp_sts   (dp_sts),
    .out_data (out_data)
  );

endmodule
